@@ rtl/core/modular_prime_field_alu_defines.svh @@
// Assertion macros for the modular prime field ALU checker.
// Expect signals named clk and rst in the scope where they are used.
`ifndef MODULAR_PRIME_FIELD_ALU_DEFINES_SVH
`define MODULAR_PRIME_FIELD_ALU_DEFINES_SVH

// Concurrent assertion on the rising clock edge, switched off during reset.
`define MPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  `MPF_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ rtl/core/mpf_pkg.sv @@
// Package for the modular prime field ALU: field constants, widths, codes and
// the command and status structs between controller and datapath. No dependencies.
package mpf_pkg;

  localparam longint unsigned MODULUS = 64'd998244353;

  // Residue width and the product width seen by the reducer.
  localparam int RW  = $clog2(MODULUS + 1);
  localparam int PW  = 2 * RW;
  localparam int MUW = RW + 1;

  // Barrett constant floor(2^(2*RW) / MODULUS).
  localparam longint unsigned MU = (64'd1 << PW) / MODULUS;

  localparam int OPC_W = 3;
  localparam int A_W   = 30;
  localparam int B_W   = 64;
  localparam int RES_W = 30;

  // The 64-bit operand is folded in by Horner steps of one digit each.
  localparam int DIG_W = 16;
  localparam int NDIG  = B_W / DIG_W;
  localparam int CNT_W = $clog2(NDIG);

  typedef logic [RW-1:0] residue_t;

  localparam residue_t MOD_R     = RW'(MODULUS);
  localparam residue_t ONE_R     = RW'(1);
  localparam residue_t DIG_SCALE = RW'(64'd1 << DIG_W);
  localparam logic [B_W-1:0] INV_EXP = B_W'(MODULUS - 2);

  typedef enum logic [OPC_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_POW = 3'd3,
    OP_DIV = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    SRC_A,
    SRC_DIGIT,
    SRC_XY,
    SRC_ACC_SQ,
    SRC_SQ_SQ,
    SRC_X_ACC
  } mm_src_t;

  typedef enum logic [1:0] {
    DST_X,
    DST_Y,
    DST_ACC,
    DST_SQ
  } mm_dst_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_WAIT_A,
    ST_RED_B,
    ST_WAIT_B,
    ST_DISPATCH,
    ST_POW_CHK,
    ST_POW_MUL,
    ST_WAIT_MUL,
    ST_POW_SQ,
    ST_WAIT_SQ,
    ST_MUL_ISSUE,
    ST_WAIT_FIN,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic    load;
    logic    mm_start;
    mm_src_t mm_src;
    logic    mm_wr;
    mm_dst_t mm_dst;
    logic    e_shift;
    logic    pow_init;
    logic    res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic             mm_done;
    logic             e_zero;
    logic             e_bit0;
    logic             e_rest_zero;
    logic [OPC_W-1:0] opcode;
  } dp_status_t;

endpackage

@@ rtl/core/mpf_req_if.sv @@
// Request channel of the modular prime field ALU: valid, ready and one item.
// Depends on mpf_pkg for the field widths.
interface mpf_req_if;
  import mpf_pkg::*;

  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [A_W-1:0]   a;
  logic [B_W-1:0]   b;

  modport source (output valid, opcode, a, b, input ready);
  modport sink   (input valid, opcode, a, b, output ready);
endinterface

@@ rtl/core/mpf_rsp_if.sv @@
// Response channel of the modular prime field ALU: valid, ready and the result.
// Depends on mpf_pkg for the field width.
interface mpf_rsp_if;
  import mpf_pkg::*;

  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

@@ rtl/core/mpf_modmul.sv @@
// Pipelined modular multiply-add: (opa * opb + addend) mod MODULUS by Barrett reduction.
// Five register stages, one start at a time from the controller. Depends on mpf_pkg.
module mpf_modmul (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mpf_pkg::residue_t opa,
  input  mpf_pkg::residue_t opb,
  input  logic [mpf_pkg::PW-1:0] addend,
  output logic              done,
  output mpf_pkg::residue_t result
);
  import mpf_pkg::*;

  localparam logic [MUW-1:0] MU_C = MUW'(MU);
  localparam logic [RW+1:0]  M1_C = (RW + 2)'(MODULUS);
  localparam logic [RW+1:0]  M2_C = (RW + 2)'(2 * MODULUS);

  logic [4:0]         vld;
  logic [PW-1:0]      prod_c;
  logic [PW-1:0]      p1;
  logic [PW-1:0]      p2;
  logic [PW-1:0]      p3;
  logic [2*MUW-1:0]   t2;
  logic [MUW+RW-1:0]  qm3;
  logic [RW+1:0]      r4;
  logic [RW+1:0]      r5_c;
  residue_t           r5;

  assign prod_c = opa * opb;

  // The remainder after the estimate is below three times the modulus.
  always_comb begin
    if (r4 >= M2_C) begin
      r5_c = r4 - M2_C;
    end else if (r4 >= M1_C) begin
      r5_c = r4 - M1_C;
    end else begin
      r5_c = r4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    p1  <= prod_c + addend;
    t2  <= p1[PW-1:RW-1] * MU_C;
    p2  <= p1;
    qm3 <= t2[2*MUW-1:MUW] * MOD_R;
    p3  <= p2;
    r4  <= p3[RW+1:0] - qm3[RW+1:0];
    r5  <= r5_c[RW-1:0];
  end

  assign done   = vld[4];
  assign result = r5;

endmodule

@@ rtl/core/mpf_datapath.sv @@
// Datapath of the modular prime field ALU: operand, accumulator and exponent
// registers, the shared modular multiplier and the result register. Depends on mpf_pkg.
module mpf_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [mpf_pkg::OPC_W-1:0] opcode,
  input  logic [mpf_pkg::A_W-1:0]   a,
  input  logic [mpf_pkg::B_W-1:0]   b,
  input  mpf_pkg::dp_cmd_t          cmd,
  output mpf_pkg::dp_status_t       status,
  output logic [mpf_pkg::RES_W-1:0] result
);
  import mpf_pkg::*;

  logic [OPC_W-1:0] opc;
  logic [A_W-1:0]   a_r;
  logic [B_W-1:0]   bsh;
  logic [B_W-1:0]   e;
  residue_t         x;
  residue_t         y;
  residue_t         acc;
  residue_t         sq;
  logic [RES_W-1:0] res;

  residue_t         mm_a;
  residue_t         mm_b;
  logic [PW-1:0]    mm_add;
  logic             mm_done;
  residue_t         mm_res;

  logic [RW:0]      sum_c;
  logic [RW:0]      dif_c;
  residue_t         res_c;

  always_comb begin
    mm_a   = '0;
    mm_b   = '0;
    mm_add = '0;
    case (cmd.mm_src)
      SRC_A:      mm_add = PW'(a_r);
      SRC_DIGIT: begin
        mm_a   = y;
        mm_b   = DIG_SCALE;
        mm_add = PW'(bsh[B_W-1 -: DIG_W]);
      end
      SRC_XY: begin
        mm_a = x;
        mm_b = y;
      end
      SRC_ACC_SQ: begin
        mm_a = acc;
        mm_b = sq;
      end
      SRC_SQ_SQ: begin
        mm_a = sq;
        mm_b = sq;
      end
      SRC_X_ACC: begin
        mm_a = x;
        mm_b = acc;
      end
      default: mm_add = '0;
    endcase
  end

  mpf_modmul u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mm_start),
    .opa    (mm_a),
    .opb    (mm_b),
    .addend (mm_add),
    .done   (mm_done),
    .result (mm_res)
  );

  // Both operands are residues, so one conditional subtraction finishes add and subtract.
  always_comb begin
    sum_c = {1'b0, x} + {1'b0, y};
    dif_c = {1'b0, x} + {1'b0, MOD_R} - {1'b0, y};
    case (opc) inside
      OP_ADD:  res_c = (sum_c >= {1'b0, MOD_R}) ? RW'(sum_c - {1'b0, MOD_R}) : sum_c[RW-1:0];
      OP_SUB:  res_c = (dif_c >= {1'b0, MOD_R}) ? RW'(dif_c - {1'b0, MOD_R}) : dif_c[RW-1:0];
      OP_MUL, OP_POW, OP_DIV: res_c = acc;
      default: res_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opc <= opcode;
      a_r <= a;
      bsh <= b;
      e   <= b;
      y   <= '0;
    end
    if (cmd.mm_wr) begin
      case (cmd.mm_dst)
        DST_X:   x <= mm_res;
        DST_Y: begin
          y   <= mm_res;
          bsh <= bsh << DIG_W;
        end
        DST_ACC: acc <= mm_res;
        DST_SQ:  sq  <= mm_res;
        default: x   <= mm_res;
      endcase
    end
    // Divide raises the reduced divisor to the Fermat exponent.
    if (cmd.pow_init) begin
      acc <= ONE_R;
      if (opc == OP_DIV) begin
        sq <= y;
        e  <= INV_EXP;
      end else begin
        sq <= x;
      end
    end
    if (cmd.e_shift) begin
      e <= e >> 1;
    end
    if (cmd.res_load) begin
      res <= RES_W'(res_c);
    end
  end

  assign status.mm_done     = mm_done;
  assign status.e_zero      = (e == '0);
  assign status.e_bit0      = e[0];
  assign status.e_rest_zero = (e[B_W-1:1] == '0);
  assign status.opcode      = opc;
  assign result             = res;

endmodule

@@ rtl/core/mpf_ctrl.sv @@
// Controller of the modular prime field ALU: sequences operand reduction,
// square-and-multiply and the output handshake. Depends on mpf_pkg.
module mpf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mpf_pkg::dp_status_t status,
  output mpf_pkg::dp_cmd_t    cmd
);
  import mpf_pkg::*;

  ctrl_state_t      state;
  ctrl_state_t      state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             rsp_valid;
  logic             rsp_valid_next;
  logic             take;

  // The output register may be refilled in the cycle its item is taken.
  assign take     = !rsp_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RED_A;
          cnt_next   = '0;
        end
      end
      ST_RED_A:  state_next = ST_WAIT_A;
      ST_WAIT_A: if (status.mm_done) state_next = ST_RED_B;
      ST_RED_B:  state_next = ST_WAIT_B;
      ST_WAIT_B: begin
        if (status.mm_done) begin
          cnt_next   = cnt + 1'b1;
          state_next = (cnt == CNT_W'(NDIG - 1)) ? ST_DISPATCH : ST_RED_B;
        end
      end
      ST_DISPATCH: begin
        case (status.opcode) inside
          OP_MUL:         state_next = ST_MUL_ISSUE;
          OP_POW, OP_DIV: state_next = ST_POW_CHK;
          default:        state_next = ST_FINISH;
        endcase
      end
      ST_POW_CHK: begin
        if (status.e_zero) begin
          state_next = (status.opcode == OP_DIV) ? ST_MUL_ISSUE : ST_FINISH;
        end else if (status.e_bit0) begin
          state_next = ST_POW_MUL;
        end else begin
          state_next = ST_POW_SQ;
        end
      end
      ST_POW_MUL: state_next = ST_WAIT_MUL;
      ST_WAIT_MUL: begin
        // No squaring is needed once the top exponent bit is consumed.
        if (status.mm_done) begin
          state_next = status.e_rest_zero ? ST_POW_CHK : ST_POW_SQ;
        end
      end
      ST_POW_SQ:    state_next = ST_WAIT_SQ;
      ST_WAIT_SQ:   if (status.mm_done) state_next = ST_POW_CHK;
      ST_MUL_ISSUE: state_next = ST_WAIT_FIN;
      ST_WAIT_FIN:  if (status.mm_done) state_next = ST_FINISH;
      ST_FINISH:    if (take) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.mm_src = SRC_A;
    cmd.mm_dst = DST_X;
    unique case (state)
      ST_IDLE:   cmd.load = in_valid;
      ST_RED_A: begin
        cmd.mm_start = 1'b1;
        cmd.mm_src   = SRC_A;
      end
      ST_WAIT_A: begin
        cmd.mm_wr  = status.mm_done;
        cmd.mm_dst = DST_X;
      end
      ST_RED_B: begin
        cmd.mm_start = 1'b1;
        cmd.mm_src   = SRC_DIGIT;
      end
      ST_WAIT_B: begin
        cmd.mm_wr  = status.mm_done;
        cmd.mm_dst = DST_Y;
      end
      ST_DISPATCH: begin
        cmd.pow_init = (status.opcode == OP_POW) || (status.opcode == OP_DIV);
      end
      ST_POW_CHK: cmd.load = 1'b0;
      ST_POW_MUL: begin
        cmd.mm_start = 1'b1;
        cmd.mm_src   = SRC_ACC_SQ;
      end
      ST_WAIT_MUL: begin
        cmd.mm_wr   = status.mm_done;
        cmd.mm_dst  = DST_ACC;
        cmd.e_shift = status.mm_done && status.e_rest_zero;
      end
      ST_POW_SQ: begin
        cmd.mm_start = 1'b1;
        cmd.mm_src   = SRC_SQ_SQ;
      end
      ST_WAIT_SQ: begin
        cmd.mm_wr   = status.mm_done;
        cmd.mm_dst  = DST_SQ;
        cmd.e_shift = status.mm_done;
      end
      ST_MUL_ISSUE: begin
        cmd.mm_start = 1'b1;
        cmd.mm_src   = (status.opcode == OP_DIV) ? SRC_X_ACC : SRC_XY;
      end
      ST_WAIT_FIN: begin
        cmd.mm_wr  = status.mm_done;
        cmd.mm_dst = DST_ACC;
      end
      ST_FINISH: cmd.res_load = take;
      default:   cmd.load = 1'b0;
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      rsp_valid_next = 1'b1;
    end else if (out_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  assign out_valid = rsp_valid;

endmodule

@@ rtl/core/modular_prime_field_alu.sv @@
// Each modular product passes through the five-stage Barrett multiplier, and operand
// reduction takes five of them. One item is in work at a time; the next is taken the cycle
// after the result is loaded into the output register. Synchronous reset returns the
// controller to idle and empties the output; no clearing pass.
module modular_prime_field_alu (
  input logic      clk,
  input logic      rst,
  mpf_req_if.sink  req,
  mpf_rsp_if.source rsp
);
  import mpf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mpf_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .opcode (req.opcode),
    .a      (req.a),
    .b      (req.b),
    .cmd    (cmd),
    .status (status),
    .result (rsp.result)
  );

endmodule

@@ rtl/core/mpf_checker.sv @@
// Port-level checker for the modular prime field ALU and its bind to the top level.
// Depends on mpf_pkg and the assertion macros in modular_prime_field_alu_defines.svh.
`include "modular_prime_field_alu_defines.svh"

module mpf_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [mpf_pkg::RES_W-1:0] out_result
);
  import mpf_pkg::*;

  // Only one item is in work, so ready must drop straight after an item is taken.
  `MPF_ASSERT_NEXT(a_ready_drops, in_valid && in_ready, !in_ready, "ready held after accept")
  `MPF_ASSERT(a_res_range, out_valid |-> (out_result < MODULUS), "result not a residue")
  `MPF_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid, "result valid dropped")
  `MPF_ASSERT_NEXT(a_res_hold, out_valid && !out_ready, $stable(out_result), "result changed")

endmodule

bind modular_prime_field_alu mpf_checker u_mpf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_result (rsp.result)
);
